### hw/rtl/ttlag_pkg.sv
// Shared types, constants and codes for the texture-tile load address generator.
package ttlag_pkg;

    // Texture memory size in bytes (a power of two) and texel coordinate width.
    localparam int TMEM_BYTES = 4096;
    localparam int COORD_BITS = 10;

    // Derived and fixed widths.
    localparam int TMEM_AW      = $clog2(TMEM_BYTES);
    localparam int END_BITS     = COORD_BITS + 1;
    localparam int IMG_W_BITS   = 11;
    localparam int PROD_BITS    = IMG_W_BITS + END_BITS;
    localparam int SRC_BITS     = 23;
    localparam int TMEM_OUT_BITS = 12;
    localparam int SIZE_BITS    = 12;
    localparam int BASE_BITS    = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 11;

    // Reset values of the configuration registers.
    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST = IMG_W_BITS'(1);
    localparam logic [1:0]            BYTE_SWAP_RST   = 2'd3;

    // Action codes of an input word.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYTE_SWAP   = CFG_IDX_BITS'(1);

    // Texel size codes.
    typedef enum logic [1:0] {
        SZ_4BIT  = 2'd0,
        SZ_8BIT  = 2'd1,
        SZ_16BIT = 2'd2,
        SZ_32BIT = 2'd3
    } t_size;

    // Input word.
    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] upper_left_s;
        logic [COORD_BITS-1:0] upper_left_t;
        logic [COORD_BITS-1:0] lower_right_s;
        logic [COORD_BITS-1:0] lower_right_t;
        logic [BASE_BITS-1:0]  tmem_base;
        logic [1:0]            size_code;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic                        write_enable;
        logic [SRC_BITS-1:0]         source_address;
        logic [TMEM_OUT_BITS-1:0]    tmem_address;
        logic                        last_of_step;
        logic                        load_done;
        logic signed [SIZE_BITS-1:0] texture_width;
        logic signed [SIZE_BITS-1:0] texture_height;
    } t_out_word;

    // Control from the top level to the walk unit.
    typedef struct packed {
        logic item_valid;
        logic out_ready;
    } t_walk_ctl;

    // Status from the walk unit to the top level.
    typedef struct packed {
        logic emit;
        logic consume;
    } t_walk_sts;

endpackage

### hw/rtl/ttlag_walk.sv
// Walk unit: rectangle state, per-texel address computation and byte sequencing.
module ttlag_walk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ttlag_pkg::t_walk_ctl                i_ctl,
    input  ttlag_pkg::t_in_word                 i_item,
    input  logic [ttlag_pkg::IMG_W_BITS-1:0]    i_image_width,
    input  logic [1:0]                          i_byte_swap,
    output ttlag_pkg::t_walk_sts                o_sts,
    output ttlag_pkg::t_out_word                o_result
);
    import ttlag_pkg::*;

    // Walk state.
    logic                  r_active;
    logic [END_BITS-1:0]   r_cur_s;
    logic [END_BITS-1:0]   r_cur_t;
    logic [COORD_BITS-1:0] r_row_s;
    logic [END_BITS-1:0]   r_end_s;
    logic [END_BITS-1:0]   r_end_t;
    logic [TMEM_AW-1:0]    r_tmem_ptr;
    t_size                 r_size;
    logic [1:0]            r_k;

    logic                  is_step;
    logic [PROD_BITS-1:0]  prod;
    logic [SRC_BITS-1:0]   idx;
    logic [SRC_BITS-1:0]   base;
    logic [1:0]            last_k;
    logic                  item_last;
    logic [END_BITS-1:0]   start_lrs;
    logic [END_BITS-1:0]   start_lrt;
    logic [END_BITS:0]     n_cur_s;
    logic [END_BITS-1:0]   n_cur_t;

    assign is_step = (i_item.action == ACT_STEP);

    // Texel index into the source image, then scaled to bytes by texel size.
    assign prod = PROD_BITS'(i_image_width) * PROD_BITS'(r_cur_t);
    assign idx  = SRC_BITS'(prod) + SRC_BITS'(r_cur_s);

    always_comb begin
        case (r_size)
            SZ_4BIT: begin
                base   = idx >> 1;
                last_k = 2'd0;
            end
            SZ_8BIT: begin
                base   = idx;
                last_k = 2'd0;
            end
            SZ_16BIT: begin
                base   = idx << 1;
                last_k = 2'd1;
            end
            default: begin
                base   = idx << 2;
                last_k = 2'd3;
            end
        endcase
    end

    // Exclusive rectangle ends of a start word.
    assign start_lrs = END_BITS'(i_item.lower_right_s) + END_BITS'(1);
    assign start_lrt = END_BITS'(i_item.lower_right_t) + END_BITS'(1);

    // A start word and an idle step give one word; a texel gives one per byte.
    assign item_last = !is_step || !r_active || (r_k == last_k);
    assign o_sts.emit    = i_ctl.item_valid && i_ctl.out_ready;
    assign o_sts.consume = o_sts.emit && item_last;

    // Result word for the current byte.
    always_comb begin
        o_result = '0;
        o_result.last_of_step = 1'b1;
        if (!is_step) begin
            o_result.texture_width  = SIZE_BITS'(start_lrs) - SIZE_BITS'(i_item.upper_left_s);
            o_result.texture_height = SIZE_BITS'(start_lrt) - SIZE_BITS'(i_item.upper_left_t);
        end else if (!r_active) begin
            o_result.load_done = 1'b1;
        end else begin
            o_result.write_enable   = 1'b1;
            o_result.source_address = (base | SRC_BITS'(r_k)) ^ SRC_BITS'(i_byte_swap);
            o_result.tmem_address   = TMEM_OUT_BITS'(r_tmem_ptr + TMEM_AW'(r_k));
            o_result.last_of_step   = (r_k == last_k);
        end
    end

    // Next texel position after the last byte of a texel.
    assign n_cur_s = (END_BITS+1)'(r_cur_s) + ((r_size == SZ_4BIT) ? (END_BITS+1)'(2)
                                                                   : (END_BITS+1)'(1));
    assign n_cur_t = r_cur_t + END_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_cur_s    <= '0;
            r_cur_t    <= '0;
            r_row_s    <= '0;
            r_end_s    <= '0;
            r_end_t    <= '0;
            r_tmem_ptr <= '0;
            r_size     <= SZ_4BIT;
            r_k        <= '0;
        end else if (o_sts.emit) begin
            if (!is_step) begin
                // A start abandons any walk in progress.
                r_row_s    <= i_item.upper_left_s;
                r_cur_s    <= END_BITS'(i_item.upper_left_s);
                r_cur_t    <= END_BITS'(i_item.upper_left_t);
                r_end_s    <= start_lrs;
                r_end_t    <= start_lrt;
                r_tmem_ptr <= TMEM_AW'({i_item.tmem_base, 3'b000});
                r_size     <= t_size'(i_item.size_code);
                r_active   <= (END_BITS'(i_item.upper_left_s) < start_lrs) &&
                              (END_BITS'(i_item.upper_left_t) < start_lrt);
                r_k        <= '0;
            end else if (r_active) begin
                if (item_last) begin
                    r_k        <= '0;
                    r_tmem_ptr <= r_tmem_ptr + TMEM_AW'(last_k) + TMEM_AW'(1);
                    // The row ends once the column reaches or passes its end.
                    if (n_cur_s >= (END_BITS+1)'(r_end_s)) begin
                        r_cur_s <= END_BITS'(r_row_s);
                        r_cur_t <= n_cur_t;
                        if (n_cur_t >= r_end_t) begin
                            r_active <= 1'b0;
                        end
                    end else begin
                        r_cur_s <= END_BITS'(n_cur_s);
                    end
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

endmodule

### hw/rtl/texture_tile_load_address_gen.sv
// Top level of the texture-tile load address generator.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_data  (t_in_word)
//   out       output     o_out_valid / i_out_stall  o_out_data (t_out_word)
//   cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A word enters an input register, and each result word leaves through an output
// register. A start word or a step after the walk gives one result word; a texel
// step gives one result word per texel byte (1, 1, 2 or 4), and its word stays in
// the input register until its last byte is emitted.
// Reset clears the walk state and both handshakes, and sets the configuration
// registers to their defaults.
// A stall on the output holds the result register and backs up into the input.
module texture_tile_load_address_gen (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ttlag_pkg::t_in_word                   i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ttlag_pkg::t_out_word                  o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ttlag_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [ttlag_pkg::CFG_DAT_BITS-1:0]    i_cfg_data
);
    import ttlag_pkg::*;

    logic [IMG_W_BITS-1:0] r_image_width;
    logic [1:0]            r_byte_swap;
    logic                  r_in_valid;
    t_in_word              r_in;
    logic                  r_out_valid;
    t_out_word             r_out;
    logic                  n_out_valid;

    t_walk_ctl             walk_ctl;
    t_walk_sts             walk_sts;
    t_out_word             walk_result;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_byte_swap   <= BYTE_SWAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                CFG_BYTE_SWAP:   r_byte_swap   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Input register: refilled in the cycle its word finishes.
    assign o_in_stall = r_in_valid && !walk_sts.consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Walk unit between the input and output registers.
    assign walk_ctl.item_valid = r_in_valid;
    assign walk_ctl.out_ready  = !r_out_valid || !i_out_stall;

    ttlag_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (walk_ctl),
        .i_item        (r_in),
        .i_image_width (r_image_width),
        .i_byte_swap   (r_byte_swap),
        .o_sts         (walk_sts),
        .o_result      (walk_result)
    );

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (walk_ctl.out_ready) begin
            n_out_valid = walk_sts.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_sts.emit) begin
            r_out <= walk_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/ttlag_checker.sv
// Port-level checker for the texture-tile load address generator, with its bind.
module ttlag_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  ttlag_pkg::t_out_word o_out_data
);
    import ttlag_pkg::*;

    // No result word is shown in the cycle after reset.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // Every word that is not a byte write closes its step.
    a_nonwrite_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_enable |-> o_out_data.last_of_step)
        else $error("non-write word without last_of_step");

    // A done report carries no addresses.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.load_done |->
            !o_out_data.write_enable && o_out_data.source_address == '0 &&
            o_out_data.tmem_address == '0)
        else $error("done word with write or address");

    // Bytes of one texel follow at once, at consecutive texture-memory addresses.
    a_bytes_consecutive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.write_enable &&
            !o_out_data.last_of_step |=>
            o_out_valid && o_out_data.write_enable &&
            o_out_data.tmem_address == $past(o_out_data.tmem_address) + TMEM_OUT_BITS'(1))
        else $error("texel bytes not consecutive");

endmodule

bind texture_tile_load_address_gen ttlag_checker u_ttlag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### verif/tb_texture_tile_load_address_gen.sv
// Self-checking testbench for the texture-tile load address generator.
module tb_texture_tile_load_address_gen;
    import ttlag_pkg::*;

    localparam int IDLE_PCT   = 21;
    localparam int SETTLE_CYC = 8;

    // One row of the directed stimulus table.
    typedef struct packed {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_word                 i_in_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_word                o_out_data;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DAT_BITS-1:0]  i_cfg_data;

    // Predicted copy of the configuration and the walk state.
    logic [IMG_W_BITS-1:0]  img_width;
    logic [1:0]             swap_xor;
    bit                     walk_on;
    logic [END_BITS-1:0]    col;
    logic [END_BITS-1:0]    row;
    logic [COORD_BITS-1:0]  row_first;
    logic [END_BITS-1:0]    end_col;
    logic [END_BITS-1:0]    end_row;
    logic [TMEM_AW-1:0]     tmem_ptr;
    t_size                  cur_size;

    t_out_word  due_words[$];
    t_out_word  oldest_due;
    t_stim_row  directed_rows [22];
    int         words_sent;
    bit         calm;
    bit         any_mismatch;

    texture_tile_load_address_gen i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Run limit, far beyond the slowest correct run.
    initial begin
        #(20 * 200000);
        $display("** texture_tile_load_address_gen: FAILED **");
        $finish;
    end

    // Works out the result words that one accepted input word causes.
    function automatic void predict_load_words(input t_in_word w);
        int unsigned texel;
        int unsigned base;
        int          nbytes;
        t_out_word   r;
        r = '0;
        if (w.action == ACT_START) begin
            row_first = w.upper_left_s;
            col       = END_BITS'(w.upper_left_s);
            row       = END_BITS'(w.upper_left_t);
            end_col   = END_BITS'(w.lower_right_s) + 1'b1;
            end_row   = END_BITS'(w.lower_right_t) + 1'b1;
            tmem_ptr  = TMEM_AW'({w.tmem_base, 3'b000});
            cur_size  = t_size'(w.size_code);
            walk_on   = (col < end_col) && (row < end_row);
            r.last_of_step   = 1'b1;
            r.texture_width  = SIZE_BITS'(end_col) - SIZE_BITS'(w.upper_left_s);
            r.texture_height = SIZE_BITS'(end_row) - SIZE_BITS'(w.upper_left_t);
            due_words.push_back(r);
            return;
        end
        if (!walk_on) begin
            r.last_of_step = 1'b1;
            r.load_done    = 1'b1;
            due_words.push_back(r);
            return;
        end
        texel = 32'(img_width) * 32'(row) + 32'(col);
        case (cur_size)
            SZ_4BIT: begin
                base = texel >> 1;
                nbytes = 1;
            end
            SZ_8BIT: begin
                base = texel;
                nbytes = 1;
            end
            SZ_16BIT: begin
                base = texel << 1;
                nbytes = 2;
            end
            default: begin
                base = texel << 2;
                nbytes = 4;
            end
        endcase
        for (int k = 0; k < nbytes; k++) begin
            r = '0;
            r.write_enable   = 1'b1;
            r.source_address = SRC_BITS'((base | k) ^ swap_xor);
            r.tmem_address   = TMEM_OUT_BITS'(tmem_ptr);
            r.last_of_step   = (k == nbytes - 1);
            due_words.push_back(r);
            tmem_ptr = tmem_ptr + 1'b1;
        end
        // Row-major walk; a 4-bit column may jump past the end of the row.
        col = col + ((cur_size == SZ_4BIT) ? 2 : 1);
        if (col >= end_col) begin
            col = END_BITS'(row_first);
            row = row + 1'b1;
            if (row >= end_row)
                walk_on = 1'b0;
        end
    endfunction

    function automatic t_in_word start_word(input int uls, input int ult, input int lrs,
                                            input int lrt, input int base, input t_size sz);
        t_in_word w;
        w.action        = ACT_START;
        w.upper_left_s  = COORD_BITS'(uls);
        w.upper_left_t  = COORD_BITS'(ult);
        w.lower_right_s = COORD_BITS'(lrs);
        w.lower_right_t = COORD_BITS'(lrt);
        w.tmem_base     = BASE_BITS'(base);
        w.size_code     = sz;
        return w;
    endfunction

    // A step word carries random contents in the fields that it ignores.
    function automatic t_in_word step_word();
        logic [63:0] junk;
        t_in_word    w;
        junk     = {$urandom, $urandom};
        w        = junk[$bits(t_in_word)-1:0];
        w.action = ACT_STEP;
        return w;
    endfunction

    function automatic t_out_word done_word();
        t_out_word r;
        r = '0;
        r.last_of_step = 1'b1;
        r.load_done    = 1'b1;
        return r;
    endfunction

    function automatic t_out_word size_word(input int w, input int h);
        t_out_word r;
        r = '0;
        r.last_of_step   = 1'b1;
        r.texture_width  = SIZE_BITS'(w);
        r.texture_height = SIZE_BITS'(h);
        return r;
    endfunction

    function automatic t_stim_row stim_row(input t_in_word w, input bit typed,
                                           input t_out_word want);
        t_stim_row s;
        s.word  = w;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // Sends one word, with random idle cycles ahead of it, and predicts on acceptance.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_load_words(w);
        if (typed) begin
            void'(due_words.pop_back());
            due_words.push_back(want);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender until every expected word has come, then lets the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_IMAGE_WIDTH: img_width = val;
            CFG_BYTE_SWAP:   swap_xor  = val[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Coordinates lean toward the top of the range now and then.
    function automatic int pick_coord();
        return ($urandom_range(3) == 0) ? 1023 - $urandom_range(3) : $urandom_range(1023);
    endfunction

    // Mostly complete small loads with random contents, plus empty rectangles,
    // abandoned walks and stray steps.
    task automatic random_loads(input int quota);
        int stop_at;
        int pick;
        int uls;
        int ult;
        int lrs;
        int lrt;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            uls  = pick_coord();
            ult  = pick_coord();
            if (pick < 70) begin
                lrs = uls + $urandom_range(3);
                lrt = ult + $urandom_range(2);
                if (lrs > 1023)
                    lrs = 1023;
                if (lrt > 1023)
                    lrt = 1023;
                send_word(start_word(uls, ult, lrs, lrt, $urandom_range(511),
                                     t_size'($urandom_range(3))), 1'b0, '0);
                while (walk_on && $urandom_range(99) >= 8)
                    send_word(step_word(), 1'b0, '0);
                if (!walk_on)
                    send_word(step_word(), 1'b0, '0);
            end else if (pick < 82) begin
                lrs = uls;
                lrt = ult;
                if ($urandom_range(1)) begin
                    if (uls == 0)
                        uls = 1;
                    lrs = $urandom_range(uls - 1);
                end else begin
                    if (ult == 0)
                        ult = 1;
                    lrt = $urandom_range(ult - 1);
                end
                send_word(start_word(uls, ult, lrs, lrt, $urandom_range(511),
                                     t_size'($urandom_range(3))), 1'b0, '0);
                send_word(step_word(), 1'b0, '0);
            end else begin
                send_word(step_word(), 1'b0, '0);
            end
        end
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            any_mismatch = 1'b1;
        end
    endtask

    // Receiver stall, random except during the calm stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Each accepted result word is checked against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %p",
                         $time, o_out_data);
                any_mismatch = 1'b1;
            end else begin
                oldest_due = due_words.pop_front();
                compare_field("write_enable", oldest_due.write_enable,
                              o_out_data.write_enable);
                compare_field("source_address", oldest_due.source_address,
                              o_out_data.source_address);
                compare_field("tmem_address", oldest_due.tmem_address,
                              o_out_data.tmem_address);
                compare_field("last_of_step", oldest_due.last_of_step,
                              o_out_data.last_of_step);
                compare_field("load_done", oldest_due.load_done, o_out_data.load_done);
                compare_field("texture_width", 12'(oldest_due.texture_width),
                              12'(o_out_data.texture_width));
                compare_field("texture_height", 12'(oldest_due.texture_height),
                              12'(o_out_data.texture_height));
            end
        end
    end

    // Main sequence: reset, directed table, then random phases under several settings.
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        img_width    = IMAGE_WIDTH_RST;
        swap_xor     = BYTE_SWAP_RST;
        walk_on      = 1'b0;
        col          = '0;
        row          = '0;
        row_first    = '0;
        end_col      = '0;
        end_row      = '0;
        tmem_ptr     = '0;
        cur_size     = SZ_4BIT;
        words_sent   = 0;
        calm         = 1'b0;
        any_mismatch = 1'b0;

        directed_rows = '{
            // Step straight after reset reports done.
            stim_row(step_word(), 1'b1, done_word()),
            // Full-range rectangle, 32-bit texels; the texture memory wraps.
            stim_row(start_word(0, 0, 1023, 1023, 511, SZ_32BIT), 1'b1,
                     size_word(1024, 1024)),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            // Corners swapped: negative sizes and nothing to walk.
            stim_row(start_word(1023, 1023, 0, 0, 0, SZ_4BIT), 1'b1,
                     size_word(-1022, -1022)),
            stim_row(step_word(), 1'b1, done_word()),
            // Odd width at 4 bits: the column skips past the row end.
            stim_row(start_word(0, 1022, 2, 1023, 100, SZ_4BIT), 1'b1, size_word(3, 2)),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b1, done_word()),
            // 8-bit walk abandoned by a new 16-bit start.
            stim_row(start_word(5, 7, 6, 7, 1, SZ_8BIT), 1'b1, size_word(2, 1)),
            stim_row(step_word(), 1'b0, '0),
            stim_row(start_word(3, 3, 3, 4, 256, SZ_16BIT), 1'b1, size_word(1, 2)),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b1, done_word()),
            // Single texel at the far column.
            stim_row(start_word(1023, 0, 1023, 0, 510, SZ_32BIT), 1'b1, size_word(1, 1)),
            stim_row(step_word(), 1'b0, '0),
            stim_row(step_word(), 1'b1, done_word())
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n])
            send_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_IMAGE_WIDTH, 11'd1024);
                    write_reg(CFG_BYTE_SWAP, 11'd0);
                end
                1: begin
                    // Widest image: source addresses reach near the top of their range, without overflow.
                    write_reg(CFG_IMAGE_WIDTH, 11'd2047);
                    write_reg(CFG_BYTE_SWAP, 11'd1);
                end
                2: begin
                    write_reg(CFG_IMAGE_WIDTH, 11'd1);
                    write_reg(CFG_BYTE_SWAP, 11'd2);
                    // Unused register indexes must be ignored.
                    write_reg(CFG_IDX_BITS'(2), CFG_DAT_BITS'($urandom));
                    write_reg(CFG_IDX_BITS'(3), CFG_DAT_BITS'($urandom));
                end
                default: begin
                    write_reg(CFG_IMAGE_WIDTH, CFG_DAT_BITS'($urandom_range(1024, 1)));
                    write_reg(CFG_BYTE_SWAP, CFG_DAT_BITS'($urandom_range(3)));
                end
            endcase
            calm = (phase == 0);
            random_loads(20);
            drain_results();
        end
        calm = 1'b0;

        if (!any_mismatch)
            $display("** texture_tile_load_address_gen: PASSED **");
        else
            $display("** texture_tile_load_address_gen: FAILED **");
        $finish;
    end

endmodule
